/* hw/rtl/stack_with_unique_keys_top_assert.svh */
// assertion macros for the stack block
// each macro checks on the rising clock edge and is switched off during reset
`ifndef STACK_WITH_UNIQUE_KEYS_TOP_ASSERT_SVH
`define STACK_WITH_UNIQUE_KEYS_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// condition that must hold at every edge
`define SUK_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define SUK_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define SUK_ASSERT(lbl, cond, msg)
`define SUK_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* hw/rtl/suk_pkg.sv */
package suk_pkg;

	localparam int KEY_W   = 32;
	localparam int DATA_W  = 32;
	localparam int ENTRY_W = 5;

	// operation codes
	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_POP  = 2'd1;
	localparam logic [1:0] OP_PEEK = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_DUP   = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	typedef struct packed {
		logic [1:0]               func;
		logic signed [KEY_W-1:0]  push_key;
		logic signed [DATA_W-1:0] push_data;
	} req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] top_data;
		logic [ENTRY_W-1:0]       entry_count;
		logic                     is_empty;
	} rsp_t;

	// one stored pair
	typedef struct packed {
		logic signed [KEY_W-1:0]  key;
		logic signed [DATA_W-1:0] data;
	} entry_t;

	// shift command shared by all cells
	typedef struct packed {
		logic push;
		logic pop;
	} shift_t;

endpackage

/* hw/rtl/stack_with_unique_keys_top.sv */
// lifo stack of key and data pairs with a duplicate key check
// request channel (req_valid, req_stall, req): func selects push, pop or peek;
//   push carries push_key and push_data, the other fields are ignored otherwise
// response channel (rsp_valid, rsp_stall, rsp): exactly one response per request,
//   status, popped or peeked data, entry count and empty flag after the operation
// the response is registered and shows in the cycle after the request transfer
// throughput: one request per cycle while req_stall is low; the key search compares all cells
//   in parallel and the whole row of cells shifts at once, so nothing iterates
// storage is a row of DEPTH cells, cell 0 holds the top of the stack; a push shifts
//   the row one cell down, a pop shifts it one cell up
// a cell is held when its index is below the fill count; cells carry no reset
// reset clears the fill count and the response valid, the stack starts empty
// when the receiver stalls, the response holds and req_stall rises in the same
//   cycle, so at most one response waits and no request is lost
// a push whose key is already held reports a duplicate even when the stack is full
// code 3 in func changes nothing and reports ok with data 0
module stack_with_unique_keys_top import suk_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	`include "stack_with_unique_keys_top_assert.svh"

	// count must hold the value DEPTH itself
	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    cnt_d;
	entry_t           entry_w [DEPTH];
	logic [DEPTH-1:0] hit_w;
	shift_t           shift;
	logic             take;
	logic             full;
	logic             empty;
	rsp_t             rsp_d;
	rsp_t             rsp_q;
	logic             rsp_valid_q;
	entry_t           new_entry;

	// a waiting response that is not taken blocks the next transfer
	assign req_stall = rsp_valid_q && rsp_stall;
	assign take      = req_valid && !req_stall;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);

	assign new_entry.key  = req.push_key;
	assign new_entry.data = req.push_data;

	// row of cells, top at index 0
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t up_w;
		entry_t down_w;

		if (i == 0) begin : g_first
			assign up_w = new_entry;
		end else begin : g_mid
			assign up_w = entry_w[i-1];
		end

		// the last cell keeps its own content on pop, it is no longer held then
		if (i == DEPTH - 1) begin : g_last
			assign down_w = entry_w[i];
		end else begin : g_inner
			assign down_w = entry_w[i+1];
		end

		suk_cell u_cell (
			.clk     (clk),
			.shift   (shift),
			.up      (up_w),
			.down    (down_w),
			.held    (cnt_q > CW'(i)),
			.cmp_key (req.push_key),
			.entry   (entry_w[i]),
			.hit     (hit_w[i])
		);
	end

	// operation decode, shifts only fire on a transfer
	always_comb begin
		shift         = '0;
		cnt_d         = cnt_q;
		rsp_d         = '0;
		rsp_d.status  = ST_OK;
		unique case (req.func) inside
			OP_PUSH: begin
				if (|hit_w) begin
					rsp_d.status = ST_DUP;
				end else if (full) begin
					rsp_d.status = ST_FULL;
				end else begin
					shift.push = take;
					cnt_d      = CW'(cnt_q + 1'b1);
				end
			end
			OP_POP, OP_PEEK: begin
				if (empty) begin
					rsp_d.status   = ST_EMPTY;
					rsp_d.top_data = '1;
				end else begin
					rsp_d.top_data = entry_w[0].data;
					if (req.func == OP_POP) begin
						shift.pop = take;
						cnt_d     = CW'(cnt_q - 1'b1);
					end
				end
			end
			default: begin
			end
		endcase
		rsp_d.entry_count = ENTRY_W'(cnt_d);
		rsp_d.is_empty    = (cnt_d == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (take) begin
				cnt_q <= cnt_d;
			end
			if (take) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload, loaded on every request transfer
	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`SUK_ASSERT(a_cnt_bound, cnt_q <= CW'(DEPTH), "fill count above depth")
	`SUK_ASSERT_NEXT(a_push_count, shift.push, cnt_q == CW'($past(cnt_q) + 1'b1), "push did not raise count")
	`SUK_ASSERT(a_rsp_count, !rsp_valid_q || (rsp_q.entry_count == ENTRY_W'(cnt_q)), "response count differs from fill count")
	`SUK_ASSERT(a_empty_data, !rsp_valid_q || (rsp_q.status != ST_EMPTY) || (rsp_q.top_data == '1), "empty response without all ones data")

endmodule

/* hw/rtl/suk_cell.sv */
module suk_cell import suk_pkg::*; (
	input  logic                    clk,
	input  shift_t                  shift,
	input  entry_t                  up,
	input  entry_t                  down,
	input  logic                    held,
	input  logic signed [KEY_W-1:0] cmp_key,
	output entry_t                  entry,
	output logic                    hit
);

	entry_t entry_q;

	// push moves entries away from the top, pop moves them toward it
	always_ff @(posedge clk) begin
		if (shift.push) begin
			entry_q <= up;
		end else if (shift.pop) begin
			entry_q <= down;
		end
	end

	assign entry = entry_q;
	assign hit   = held && (entry_q.key == cmp_key);

endmodule
